// ----- hdl/rvx_pkg.sv -----
// Shared types, opcode and function codes for the integer execute core.
package rvx_pkg;

	localparam int unsigned MEM_BYTES_DEFAULT = 65536;
	localparam int unsigned INSTR_BYTES = 4;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [6:0] OP_REG    = 7'h33;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_SYSTEM = 7'h73;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] OP_JAL    = 7'h6F;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_LB   = 3'd0;
	localparam logic [2:0] F3_LH   = 3'd1;
	localparam logic [2:0] F3_LW   = 3'd2;
	localparam logic [2:0] F3_LBU  = 3'd4;
	localparam logic [2:0] F3_LHU  = 3'd5;

	localparam logic [2:0] F3_SB   = 3'd0;
	localparam logic [2:0] F3_SH   = 3'd1;
	localparam logic [2:0] F3_SW   = 3'd2;

	localparam logic [2:0] F3_JALR = 3'd0;
	localparam logic [2:0] F3_ECALL = 3'd0;

	typedef enum logic [3:0] {
		CL_NONE,
		CL_ALU,
		CL_LOAD,
		CL_STORE,
		CL_BRANCH,
		CL_JAL,
		CL_JALR,
		CL_LUI,
		CL_AUIPC
	} cls_t;

	typedef enum logic [3:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_SLL,
		ALU_SLT,
		ALU_SLTU,
		ALU_XOR,
		ALU_SRL,
		ALU_SRA,
		ALU_OR,
		ALU_AND
	} alu_op_t;

	typedef struct packed {
		cls_t        cls;
		alu_op_t     alu_op;
		logic        use_imm;
		logic        imm_shift;
		logic        illegal;
		logic        wr;
		logic [2:0]  f3;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [5:0]  shamt;
		logic [31:0] imm;
	} dec_t;

endpackage

// ----- hdl/riscv_integer_execute_core.sv -----
// Top level of the integer execute core: front end, queue and back end.
//
//  Channel | Direction | Handshake             | Payload
//  in      | in        | in_valid / in_ready   | decoded instruction fields
//  out     | out       | out_valid / out_ready | next_pc, write, illegal
//  cfg     | in        | cfg_valid / cfg_ready | start_address
//
// The core sustains one instruction per cycle while the result channel does not
// stall. An instruction enters the queue on the transfer cycle, reads the register
// file on its way out of the queue, executes and has its result registered in the
// result register. Load data comes from byte banks whose read data is registered,
// and the result stage forwards its value straight into execute, so no instruction
// waits on another. Reset clears the register file valid bits and the pc at once;
// there is no clearing pass. A stall on the result channel holds the back end
// while the front end keeps filling the queue until it is full.
module riscv_integer_execute_core #(
	parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [6:0]         major_opcode,
	input  logic [2:0]         minor_code,
	input  logic [6:0]         variant_code,
	input  logic [4:0]         dest_reg,
	input  logic [4:0]         src_reg_a,
	input  logic [4:0]         src_reg_b,
	input  logic [5:0]         shift_amount,
	input  logic signed [31:0] immediate,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [63:0]        next_pc,
	output logic               write_enable,
	output logic [4:0]         write_index,
	output logic [63:0]        write_value,
	output logic               illegal,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [63:0]        start_address
);

	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_not_empty;
	rvx_pkg::dec_t q_in;
	rvx_pkg::dec_t q_out;

	// A start address transfer restarts the program counter right away.
	assign cfg_ready = 1'b1;

	rvx_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.major_opcode (major_opcode),
		.minor_code   (minor_code),
		.variant_code (variant_code),
		.dest_reg     (dest_reg),
		.src_reg_a    (src_reg_a),
		.src_reg_b    (src_reg_b),
		.shift_amount (shift_amount),
		.immediate    (immediate),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_in)
	);

	rvx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_out)
	);

	rvx_back #(
		.MEM_BYTES (MEM_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_data       (q_out),
		.q_pop        (q_pop),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_pc       (start_address),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.next_pc      (next_pc),
		.write_enable (write_enable),
		.write_index  (write_index),
		.write_value  (write_value),
		.illegal      (illegal)
	);

endmodule

// ----- hdl/rvx_front.sv -----
// Front end: accepts instructions, classifies them and pushes them into the queue.
module rvx_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [6:0]        major_opcode,
	input  logic [2:0]        minor_code,
	input  logic [6:0]        variant_code,
	input  logic [4:0]        dest_reg,
	input  logic [4:0]        src_reg_a,
	input  logic [4:0]        src_reg_b,
	input  logic [5:0]        shift_amount,
	input  logic signed [31:0] immediate,
	input  logic              q_full,
	output logic              q_push,
	output rvx_pkg::dec_t     q_data
);

	rvx_pkg::dec_t d;
	logic          writes;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		d           = '0;
		d.cls       = rvx_pkg::CL_NONE;
		d.alu_op    = rvx_pkg::ALU_ADD;
		d.f3        = minor_code;
		d.rd        = dest_reg;
		d.rs1       = src_reg_a;
		d.rs2       = src_reg_b;
		d.shamt     = shift_amount;
		d.imm       = immediate;
		writes      = 1'b0;
		case (major_opcode)
			rvx_pkg::OP_REG: begin
				d.cls = rvx_pkg::CL_ALU;
				writes = 1'b1;
				if (variant_code == rvx_pkg::F7_BASE) begin
					case (minor_code)
						rvx_pkg::F3_ADD:  d.alu_op = rvx_pkg::ALU_ADD;
						rvx_pkg::F3_SLL:  d.alu_op = rvx_pkg::ALU_SLL;
						rvx_pkg::F3_SLT:  d.alu_op = rvx_pkg::ALU_SLT;
						rvx_pkg::F3_SLTU: d.alu_op = rvx_pkg::ALU_SLTU;
						rvx_pkg::F3_XOR:  d.alu_op = rvx_pkg::ALU_XOR;
						rvx_pkg::F3_SR:   d.alu_op = rvx_pkg::ALU_SRL;
						rvx_pkg::F3_OR:   d.alu_op = rvx_pkg::ALU_OR;
						default:          d.alu_op = rvx_pkg::ALU_AND;
					endcase
				end else if (variant_code == rvx_pkg::F7_ALT && minor_code == rvx_pkg::F3_ADD) begin
					d.alu_op = rvx_pkg::ALU_SUB;
				end else if (variant_code == rvx_pkg::F7_ALT && minor_code == rvx_pkg::F3_SR) begin
					d.alu_op = rvx_pkg::ALU_SRA;
				end else begin
					d.illegal = 1'b1;
				end
			end
			rvx_pkg::OP_IMM: begin
				d.cls = rvx_pkg::CL_ALU;
				d.use_imm = 1'b1;
				d.imm_shift = 1'b1;
				writes = 1'b1;
				case (minor_code)
					rvx_pkg::F3_ADD:  d.alu_op = rvx_pkg::ALU_ADD;
					rvx_pkg::F3_SLL: begin
						d.alu_op = rvx_pkg::ALU_SLL;
						d.illegal = (variant_code != rvx_pkg::F7_BASE);
					end
					rvx_pkg::F3_SLT:  d.alu_op = rvx_pkg::ALU_SLT;
					rvx_pkg::F3_SLTU: d.alu_op = rvx_pkg::ALU_SLTU;
					rvx_pkg::F3_XOR:  d.alu_op = rvx_pkg::ALU_XOR;
					rvx_pkg::F3_SR: begin
						if (variant_code == rvx_pkg::F7_BASE) begin
							d.alu_op = rvx_pkg::ALU_SRL;
						end else if (variant_code == rvx_pkg::F7_ALT) begin
							d.alu_op = rvx_pkg::ALU_SRA;
						end else begin
							d.illegal = 1'b1;
						end
					end
					rvx_pkg::F3_OR:   d.alu_op = rvx_pkg::ALU_OR;
					default:          d.alu_op = rvx_pkg::ALU_AND;
				endcase
			end
			rvx_pkg::OP_LOAD: begin
				d.cls = rvx_pkg::CL_LOAD;
				writes = 1'b1;
				d.illegal = !(minor_code == rvx_pkg::F3_LB || minor_code == rvx_pkg::F3_LH ||
					minor_code == rvx_pkg::F3_LW || minor_code == rvx_pkg::F3_LBU ||
					minor_code == rvx_pkg::F3_LHU);
			end
			rvx_pkg::OP_STORE: begin
				d.cls = rvx_pkg::CL_STORE;
				d.illegal = !(minor_code == rvx_pkg::F3_SB || minor_code == rvx_pkg::F3_SH ||
					minor_code == rvx_pkg::F3_SW);
			end
			rvx_pkg::OP_BRANCH: begin
				d.cls = rvx_pkg::CL_BRANCH;
				d.illegal = !(minor_code == rvx_pkg::F3_BEQ || minor_code == rvx_pkg::F3_BNE ||
					minor_code == rvx_pkg::F3_BLT || minor_code == rvx_pkg::F3_BGE ||
					minor_code == rvx_pkg::F3_BLTU || minor_code == rvx_pkg::F3_BGEU);
			end
			rvx_pkg::OP_JALR: begin
				d.cls = rvx_pkg::CL_JALR;
				writes = 1'b1;
				d.illegal = (minor_code != rvx_pkg::F3_JALR);
			end
			rvx_pkg::OP_JAL: begin
				d.cls = rvx_pkg::CL_JAL;
				writes = 1'b1;
			end
			rvx_pkg::OP_LUI: begin
				d.cls = rvx_pkg::CL_LUI;
				writes = 1'b1;
			end
			rvx_pkg::OP_AUIPC: begin
				d.cls = rvx_pkg::CL_AUIPC;
				writes = 1'b1;
			end
			rvx_pkg::OP_SYSTEM: begin
				d.illegal = (minor_code != rvx_pkg::F3_ECALL);
			end
			default: begin
				d.illegal = 1'b1;
			end
		endcase
		// An undefined instruction does nothing but advance the pc.
		if (d.illegal) begin
			d.cls = rvx_pkg::CL_NONE;
		end
		d.wr = writes && !d.illegal && (dest_reg != 5'd0);
	end

	assign q_data = d;

endmodule

// ----- hdl/rvx_queue.sv -----
// Small FIFO of classified instructions between the front end and the back end.
module rvx_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rvx_pkg::dec_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output rvx_pkg::dec_t pop_data
);

	localparam int unsigned D  = rvx_pkg::QUEUE_DEPTH;
	localparam int unsigned PW = (D > 1) ? $clog2(D) : 1;
	localparam int unsigned CW = $clog2(D + 1);

	rvx_pkg::dec_t   slots_q [D];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   count_q;

	assign full      = (count_q == CW'(D));
	assign not_empty = (count_q != '0);
	assign pop_data  = slots_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(D - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(D - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hdl/rvx_back.sv -----
// Back end: register read, execute with data memory access, and result stage.
module rvx_back #(
	parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_not_empty,
	input  rvx_pkg::dec_t q_data,
	output logic          q_pop,
	input  logic          cfg_we,
	input  logic [63:0]   cfg_pc,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [63:0]   next_pc,
	output logic          write_enable,
	output logic [4:0]    write_index,
	output logic [63:0]   write_value,
	output logic          illegal
);

	localparam int unsigned AW = $clog2(MEM_BYTES);
	localparam int unsigned RW = AW - 2;
	localparam int unsigned ROWS = MEM_BYTES / 4;

	logic adv;

	// Register file with valid bits; an entry never written reads zero.
	logic [63:0] rf_mem [32];
	logic [31:0] rf_valid_q;
	logic        rf_we;
	logic [4:0]  rf_waddr;
	logic [63:0] rf_wdata;

	logic          valid_s1;
	rvx_pkg::dec_t dec_s1;
	logic [63:0]   rs1_val_s1;
	logic [63:0]   rs2_val_s1;

	logic          valid_s2;
	logic [63:0]   npc_s2;
	logic          wr_s2;
	logic [4:0]    rd_s2;
	logic [63:0]   val_s2;
	logic          illegal_s2;
	logic          load_s2;
	logic [2:0]    f3_s2;
	logic [1:0]    lo_s2;

	logic [63:0] pc_q;
	logic [63:0] res_s2;
	logic [63:0] a_ex;
	logic [63:0] b_ex;
	logic [63:0] imm_ex;
	logic [63:0] opb_ex;
	logic [5:0]  sh_ex;
	logic [63:0] alu_ex;
	logic [63:0] seq_ex;
	logic [63:0] npc_ex;
	logic [63:0] val_ex;
	logic [63:0] addr_ex;
	logic        take_ex;

	logic [7:0]  bank_rd_q [4];
	logic [31:0] raw_s2;
	logic [63:0] load_val;

	assign adv   = !valid_s2 || out_ready;
	assign q_pop = adv && q_not_empty;

	assign rf_we    = valid_s2 && out_ready && wr_s2;
	assign rf_waddr = rd_s2;
	assign rf_wdata = res_s2;

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[rf_waddr] <= rf_wdata;
		end
		if (q_pop) begin
			if (rf_we && rf_waddr == q_data.rs1) begin
				rs1_val_s1 <= rf_wdata;
			end else begin
				rs1_val_s1 <= rf_valid_q[q_data.rs1] ? rf_mem[q_data.rs1] : '0;
			end
			if (rf_we && rf_waddr == q_data.rs2) begin
				rs2_val_s1 <= rf_wdata;
			end else begin
				rs2_val_s1 <= rf_valid_q[q_data.rs2] ? rf_mem[q_data.rs2] : '0;
			end
			dec_s1 <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_valid_q <= '0;
		end else if (rf_we) begin
			rf_valid_q[rf_waddr] <= 1'b1;
		end
	end

	// Execute: operands forwarded from the result stage.
	always_comb begin
		a_ex = (valid_s2 && wr_s2 && rd_s2 == dec_s1.rs1) ? res_s2 : rs1_val_s1;
		b_ex = (valid_s2 && wr_s2 && rd_s2 == dec_s1.rs2) ? res_s2 : rs2_val_s1;
		imm_ex = {{32{dec_s1.imm[31]}}, dec_s1.imm};
		opb_ex = dec_s1.use_imm ? imm_ex : b_ex;
		sh_ex  = dec_s1.imm_shift ? dec_s1.shamt : b_ex[5:0];
		case (dec_s1.alu_op)
			rvx_pkg::ALU_ADD:  alu_ex = a_ex + opb_ex;
			rvx_pkg::ALU_SUB:  alu_ex = a_ex - opb_ex;
			rvx_pkg::ALU_SLL:  alu_ex = a_ex << sh_ex;
			rvx_pkg::ALU_SLT:  alu_ex = {63'd0, $signed(a_ex) < $signed(opb_ex)};
			rvx_pkg::ALU_SLTU: alu_ex = {63'd0, a_ex < opb_ex};
			rvx_pkg::ALU_XOR:  alu_ex = a_ex ^ opb_ex;
			rvx_pkg::ALU_SRL:  alu_ex = a_ex >> sh_ex;
			rvx_pkg::ALU_SRA:  alu_ex = $unsigned($signed(a_ex) >>> sh_ex);
			rvx_pkg::ALU_OR:   alu_ex = a_ex | opb_ex;
			rvx_pkg::ALU_AND:  alu_ex = a_ex & opb_ex;
			default:           alu_ex = '0;
		endcase
		case (dec_s1.f3)
			rvx_pkg::F3_BEQ:  take_ex = (a_ex == b_ex);
			rvx_pkg::F3_BNE:  take_ex = (a_ex != b_ex);
			rvx_pkg::F3_BLT:  take_ex = ($signed(a_ex) < $signed(b_ex));
			rvx_pkg::F3_BGE:  take_ex = !($signed(a_ex) < $signed(b_ex));
			rvx_pkg::F3_BLTU: take_ex = (a_ex < b_ex);
			rvx_pkg::F3_BGEU: take_ex = (a_ex >= b_ex);
			default:          take_ex = 1'b0;
		endcase
		addr_ex = a_ex + imm_ex;
		seq_ex  = pc_q + 64'(rvx_pkg::INSTR_BYTES);
		npc_ex  = seq_ex;
		val_ex  = '0;
		case (dec_s1.cls)
			rvx_pkg::CL_ALU:    val_ex = alu_ex;
			rvx_pkg::CL_BRANCH: npc_ex = take_ex ? pc_q + imm_ex : seq_ex;
			rvx_pkg::CL_JAL: begin
				val_ex = seq_ex;
				npc_ex = pc_q + imm_ex;
			end
			rvx_pkg::CL_JALR: begin
				val_ex = seq_ex;
				npc_ex = {addr_ex[63:1], 1'b0};
			end
			rvx_pkg::CL_LUI:    val_ex = imm_ex;
			rvx_pkg::CL_AUIPC:  val_ex = pc_q + imm_ex;
			default:            val_ex = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (cfg_we) begin
			pc_q <= cfg_pc;
		end else if (adv && valid_s1) begin
			pc_q <= npc_ex;
		end
	end

	// Data memory: four byte banks interleaved on the low address bits.
	for (genvar k = 0; k < 4; k++) begin : g_bank
		logic [7:0]    bank_mem [ROWS];
		logic [1:0]    idx;
		logic [AW-1:0] baddr;
		logic [RW-1:0] row;
		logic          bwe;

		always_comb begin
			idx   = 2'(k) - addr_ex[1:0];
			baddr = addr_ex[AW-1:0] + AW'(idx);
			row   = baddr[AW-1:2];
			case (dec_s1.f3)
				rvx_pkg::F3_SB: bwe = (idx == 2'd0);
				rvx_pkg::F3_SH: bwe = (idx <= 2'd1);
				default:        bwe = 1'b1;
			endcase
		end

		always_ff @(posedge clk) begin
			if (adv && valid_s1 && dec_s1.cls == rvx_pkg::CL_STORE && bwe) begin
				bank_mem[row] <= b_ex[8*idx +: 8];
			end
			if (adv) begin
				bank_rd_q[k] <= bank_mem[row];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			npc_s2     <= npc_ex;
			wr_s2      <= dec_s1.wr;
			rd_s2      <= dec_s1.rd;
			val_s2     <= val_ex;
			illegal_s2 <= dec_s1.illegal;
			load_s2    <= (dec_s1.cls == rvx_pkg::CL_LOAD);
			f3_s2      <= dec_s1.f3;
			lo_s2      <= addr_ex[1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= q_not_empty;
			valid_s2 <= valid_s1;
		end
	end

	// Result stage: align and extend load data.
	always_comb begin
		raw_s2 = {bank_rd_q[lo_s2 + 2'd3], bank_rd_q[lo_s2 + 2'd2],
			bank_rd_q[lo_s2 + 2'd1], bank_rd_q[lo_s2]};
		case (f3_s2)
			rvx_pkg::F3_LB:  load_val = {{56{raw_s2[7]}}, raw_s2[7:0]};
			rvx_pkg::F3_LH:  load_val = {{48{raw_s2[15]}}, raw_s2[15:0]};
			rvx_pkg::F3_LW:  load_val = {{32{raw_s2[31]}}, raw_s2};
			rvx_pkg::F3_LBU: load_val = {56'd0, raw_s2[7:0]};
			rvx_pkg::F3_LHU: load_val = {48'd0, raw_s2[15:0]};
			default:         load_val = '0;
		endcase
		res_s2 = load_s2 ? load_val : val_s2;
	end

	assign out_valid    = valid_s2;
	assign next_pc      = npc_s2;
	assign write_enable = wr_s2;
	assign write_index  = wr_s2 ? rd_s2 : 5'd0;
	assign write_value  = wr_s2 ? res_s2 : 64'd0;
	assign illegal      = illegal_s2;

`ifndef ASSERT_OFF
	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> rf_waddr != 5'd0)
		else $error("register zero written");
	a_illegal_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && illegal_s2 |-> !wr_s2)
		else $error("undefined instruction writes a register");
	a_pc_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && !cfg_we |=> pc_q == $past(npc_ex))
		else $error("pc did not take the executed next pc");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s1 == $past(valid_s1))
		else $error("execute stage moved while results were stalled");
`endif

endmodule

// ----- tb/riscv_integer_execute_core_tb.sv -----
// Self-checking testbench for the integer execute core with a built-in execute predictor.
`timescale 1ns / 1ps

module riscv_integer_execute_core_tb;

	localparam int unsigned DATA_BYTES = rvx_pkg::MEM_BYTES_DEFAULT;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_INSTRS = 1950;

	// One decoded instruction as it is presented on the input channel.
	typedef struct {
		logic [6:0]  op;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [5:0]  shamt;
		logic [31:0] imm;
	} instr_t;

	// One retired instruction as it appears on the result channel.
	typedef struct {
		logic [63:0] npc;
		logic        we;
		logic [4:0]  widx;
		logic [63:0] wval;
		logic        bad;
	} retire_t;

	// The scoreboard holds the architectural state that the core should have
	// after every accepted instruction, and the retirements still owed.
	class exec_scoreboard;
		logic [63:0] regs [32];
		logic [63:0] pc;
		logic [7:0]  data_mem [DATA_BYTES];
		bit          data_known [DATA_BYTES];
		int unsigned stored_addrs [$];
		retire_t     owed [$];
		int          errors;

		function new();
			foreach (regs[i]) regs[i] = '0;
			pc = '0;
			errors = 0;
		endfunction

		function void restart(logic [63:0] addr);
			pc = addr;
		endfunction

		function logic [63:0] load_bytes(logic [63:0] addr, int n);
			logic [63:0] v;
			logic [15:0] a;
			v = '0;
			for (int k = 0; k < n; k++) begin
				a = 16'(addr + 64'(k));
				v[8*k +: 8] = data_mem[a];
			end
			return v;
		endfunction

		// True when every byte of an n-byte access at addr has been stored to.
		function bit bytes_known(logic [63:0] addr, int n);
			logic [15:0] a;
			for (int k = 0; k < n; k++) begin
				a = 16'(addr + 64'(k));
				if (!data_known[a]) return 0;
			end
			return 1;
		endfunction

		function void note_instr(instr_t i);
			logic [63:0] a, b, imm, seq, npc, val, addr;
			logic [5:0]  s;
			logic [15:0] p;
			bit          wr, bad, take;
			retire_t     r;
			a = (i.rs1 == 0) ? '0 : regs[i.rs1];
			b = (i.rs2 == 0) ? '0 : regs[i.rs2];
			imm = {{32{i.imm[31]}}, i.imm};
			s = b[5:0];
			seq = pc + 64'(rvx_pkg::INSTR_BYTES);
			npc = seq;
			val = '0;
			wr = 0;
			bad = 0;
			addr = a + imm;
			case (i.op)
				rvx_pkg::OP_REG: begin
					wr = 1;
					if (i.f7 == rvx_pkg::F7_BASE) begin
						case (i.f3)
							rvx_pkg::F3_ADD:  val = a + b;
							rvx_pkg::F3_SLL:  val = a << s;
							rvx_pkg::F3_SLT:  val = 64'($signed(a) < $signed(b));
							rvx_pkg::F3_SLTU: val = 64'(a < b);
							rvx_pkg::F3_XOR:  val = a ^ b;
							rvx_pkg::F3_SR:   val = a >> s;
							rvx_pkg::F3_OR:   val = a | b;
							default:          val = a & b;
						endcase
					end else if (i.f7 == rvx_pkg::F7_ALT && i.f3 == rvx_pkg::F3_ADD) begin
						val = a - b;
					end else if (i.f7 == rvx_pkg::F7_ALT && i.f3 == rvx_pkg::F3_SR) begin
						val = $signed(a) >>> s;
					end else begin
						bad = 1;
					end
				end
				rvx_pkg::OP_IMM: begin
					wr = 1;
					case (i.f3)
						rvx_pkg::F3_ADD:  val = a + imm;
						rvx_pkg::F3_SLL: begin
							if (i.f7 == rvx_pkg::F7_BASE) val = a << i.shamt;
							else bad = 1;
						end
						rvx_pkg::F3_SLT:  val = 64'($signed(a) < $signed(imm));
						rvx_pkg::F3_SLTU: val = 64'(a < imm);
						rvx_pkg::F3_XOR:  val = a ^ imm;
						rvx_pkg::F3_SR: begin
							if (i.f7 == rvx_pkg::F7_BASE) val = a >> i.shamt;
							else if (i.f7 == rvx_pkg::F7_ALT) val = $signed(a) >>> i.shamt;
							else bad = 1;
						end
						rvx_pkg::F3_OR:   val = a | imm;
						default:          val = a & imm;
					endcase
				end
				rvx_pkg::OP_LOAD: begin
					wr = 1;
					case (i.f3)
						rvx_pkg::F3_LB: begin
							val = load_bytes(addr, 1);
							val = {{56{val[7]}}, val[7:0]};
						end
						rvx_pkg::F3_LH: begin
							val = load_bytes(addr, 2);
							val = {{48{val[15]}}, val[15:0]};
						end
						rvx_pkg::F3_LW: begin
							val = load_bytes(addr, 4);
							val = {{32{val[31]}}, val[31:0]};
						end
						rvx_pkg::F3_LBU: val = load_bytes(addr, 1);
						rvx_pkg::F3_LHU: val = load_bytes(addr, 2);
						default: bad = 1;
					endcase
				end
				rvx_pkg::OP_STORE: begin
					if (i.f3 == rvx_pkg::F3_SB || i.f3 == rvx_pkg::F3_SH ||
							i.f3 == rvx_pkg::F3_SW) begin
						for (int k = 0; k < (1 << i.f3); k++) begin
							p = 16'(addr + 64'(k));
							data_mem[p] = b[8*k +: 8];
							data_known[p] = 1;
						end
						stored_addrs.push_back(int'(addr[15:0]));
						if (stored_addrs.size() > 256) void'(stored_addrs.pop_front());
					end else begin
						bad = 1;
					end
				end
				rvx_pkg::OP_BRANCH: begin
					case (i.f3)
						rvx_pkg::F3_BEQ:  take = (a == b);
						rvx_pkg::F3_BNE:  take = (a != b);
						rvx_pkg::F3_BLT:  take = $signed(a) < $signed(b);
						rvx_pkg::F3_BGE:  take = !($signed(a) < $signed(b));
						rvx_pkg::F3_BLTU: take = a < b;
						rvx_pkg::F3_BGEU: take = a >= b;
						default: begin take = 0; bad = 1; end
					endcase
					if (take) npc = pc + imm;
				end
				rvx_pkg::OP_JALR: begin
					if (i.f3 == rvx_pkg::F3_JALR) begin
						wr = 1;
						val = seq;
						npc = addr & ~64'd1;
					end else begin
						bad = 1;
					end
				end
				rvx_pkg::OP_JAL: begin
					wr = 1;
					val = seq;
					npc = pc + imm;
				end
				rvx_pkg::OP_LUI: begin
					wr = 1;
					val = imm;
				end
				rvx_pkg::OP_AUIPC: begin
					wr = 1;
					val = pc + imm;
				end
				rvx_pkg::OP_SYSTEM: begin
					if (i.f3 != rvx_pkg::F3_ECALL) bad = 1;
				end
				default: bad = 1;
			endcase
			if (bad || i.rd == 0) wr = 0;
			if (wr) regs[i.rd] = val;
			pc = npc;
			r.npc = npc;
			r.we = wr;
			r.widx = wr ? i.rd : 5'd0;
			r.wval = wr ? val : 64'd0;
			r.bad = bad;
			owed.push_back(r);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_retire(retire_t got);
			retire_t want;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, actual next_pc %h", $time, got.npc);
				return;
			end
			want = owed.pop_front();
			compare_field("next_pc", want.npc, got.npc);
			compare_field("write_enable", 64'(want.we), 64'(got.we));
			compare_field("write_index", 64'(want.widx), 64'(got.widx));
			compare_field("write_value", want.wval, got.wval);
			compare_field("illegal", 64'(want.bad), 64'(got.bad));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [6:0]         major_opcode;
	logic [2:0]         minor_code;
	logic [6:0]         variant_code;
	logic [4:0]         dest_reg;
	logic [4:0]         src_reg_a;
	logic [4:0]         src_reg_b;
	logic [5:0]         shift_amount;
	logic signed [31:0] immediate;
	logic               out_valid;
	logic               out_ready;
	logic [63:0]        next_pc;
	logic               write_enable;
	logic [4:0]         write_index;
	logic [63:0]        write_value;
	logic               illegal;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [63:0]        start_address;

	exec_scoreboard sb = new();
	int unsigned    cycle_count = 0;
	int unsigned    stall_pct;

	riscv_integer_execute_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.major_opcode (major_opcode),
		.minor_code   (minor_code),
		.variant_code (variant_code),
		.dest_reg     (dest_reg),
		.src_reg_a    (src_reg_a),
		.src_reg_b    (src_reg_b),
		.shift_amount (shift_amount),
		.immediate    (immediate),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.next_pc      (next_pc),
		.write_enable (write_enable),
		.write_index  (write_index),
		.write_value  (write_value),
		.illegal      (illegal),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.start_address(start_address)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// The run is cut off at a generous cycle limit so a hung handshake cannot
	// keep the simulation going forever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// The receiver periodically switches between stall densities, from never
	// stalling up to stalling most of the time.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_pct <= 0;
		end else begin
			if (cycle_count % 64 == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pct <= 0;
					1: stall_pct <= 25;
					2: stall_pct <= 50;
					default: stall_pct <= 85;
				endcase
			end
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Every result transfer is checked against the oldest owed retirement.
	// Handshake signals are read right after the edge, before this edge's
	// register updates land, so they reflect the values the core saw.
	always @(posedge clk) begin
		retire_t got;
		if (arst_n && out_valid && out_ready) begin
			got.npc = next_pc;
			got.we = write_enable;
			got.widx = write_index;
			got.wval = write_value;
			got.bad = illegal;
			sb.check_retire(got);
		end
	end

	// Presents one instruction and holds it until the transfer happens, then
	// lets the scoreboard execute it. The caller decides whether valid drops.
	task automatic send_instr(instr_t i);
		in_valid <= 1'b1;
		major_opcode <= i.op;
		minor_code <= i.f3;
		variant_code <= i.f7;
		dest_reg <= i.rd;
		src_reg_a <= i.rs1;
		src_reg_b <= i.rs2;
		shift_amount <= i.shamt;
		immediate <= i.imm;
		do @(posedge clk); while (!in_ready);
		sb.note_instr(i);
	endtask

	task automatic send_fields(logic [6:0] op, logic [2:0] f3, logic [6:0] f7, logic [4:0] rd,
			logic [4:0] rs1, logic [4:0] rs2, logic [5:0] shamt, logic [31:0] imm);
		instr_t i;
		i.op = op;
		i.f3 = f3;
		i.f7 = f7;
		i.rd = rd;
		i.rs1 = rs1;
		i.rs2 = rs2;
		i.shamt = shamt;
		i.imm = imm;
		send_instr(i);
	endtask

	// Waits until every owed result has come back, then lets the pipeline drain,
	// so the start address may be rewritten safely.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_start(logic [63:0] addr);
		cfg_valid <= 1'b1;
		start_address <= addr;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.restart(addr);
	endtask

	function automatic logic [31:0] pick_imm();
		case ($urandom_range(0, 5))
			0: return 32'($signed($urandom_range(0, 31)) - 16);
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return {{20{1'b0}}, 12'($urandom())};
			default: return $urandom();
		endcase
	endfunction

	// Random instruction, mostly well formed, with some opcode and function
	// noise. Loads are steered onto bytes that were already stored to.
	function automatic instr_t random_instr();
		instr_t i;
		int unsigned kind;
		logic [15:0] target;
		logic [63:0] base;
		int n;
		i.op = 7'($urandom());
		i.f3 = 3'($urandom());
		i.f7 = ($urandom_range(0, 9) < 8)
			? (($urandom_range(0, 1) == 1) ? rvx_pkg::F7_ALT : rvx_pkg::F7_BASE)
			: 7'($urandom());
		i.rd = 5'($urandom());
		i.rs1 = 5'($urandom());
		i.rs2 = 5'($urandom());
		i.shamt = 6'($urandom());
		i.imm = pick_imm();
		kind = $urandom_range(0, 99);
		if (kind < 30) i.op = rvx_pkg::OP_REG;
		else if (kind < 52) i.op = rvx_pkg::OP_IMM;
		else if (kind < 64) i.op = rvx_pkg::OP_STORE;
		else if (kind < 76) i.op = rvx_pkg::OP_LOAD;
		else if (kind < 84) i.op = rvx_pkg::OP_BRANCH;
		else if (kind < 87) i.op = rvx_pkg::OP_JAL;
		else if (kind < 90) i.op = rvx_pkg::OP_JALR;
		else if (kind < 93) i.op = rvx_pkg::OP_LUI;
		else if (kind < 95) i.op = rvx_pkg::OP_AUIPC;
		else if (kind < 97) i.op = rvx_pkg::OP_SYSTEM;
		if (i.op == rvx_pkg::OP_STORE && $urandom_range(0, 3) != 0)
			i.imm = 32'($urandom_range(0, 255));
		if (i.op == rvx_pkg::OP_LOAD && (i.f3 == rvx_pkg::F3_LB || i.f3 == rvx_pkg::F3_LH ||
				i.f3 == rvx_pkg::F3_LW || i.f3 == rvx_pkg::F3_LBU ||
				i.f3 == rvx_pkg::F3_LHU)) begin
			if (sb.stored_addrs.size() == 0) begin
				i.op = rvx_pkg::OP_STORE;
				i.f3 = rvx_pkg::F3_SW;
			end else begin
				target = 16'(sb.stored_addrs[$urandom_range(0, sb.stored_addrs.size() - 1)]);
				n = 1 << i.f3[1:0];
				if (!sb.bytes_known({48'd0, target}, n)) i.f3 = rvx_pkg::F3_LBU;
				base = (i.rs1 == 0) ? '0 : sb.regs[i.rs1];
				i.imm = {16'($urandom()), 16'(target - base[15:0])};
			end
		end
		return i;
	endfunction

	// Sends a stretch of random instructions in bursts, with random gaps
	// between bursts and some long runs with no gaps at all.
	task automatic random_phase(int count);
		int burst, gap;
		while (count > 0) begin
			burst = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			for (int k = 0; k < burst && count > 0; k++) begin
				send_instr(random_instr());
				count--;
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		major_opcode = '0;
		minor_code = '0;
		variant_code = '0;
		dest_reg = '0;
		src_reg_a = '0;
		src_reg_b = '0;
		shift_amount = '0;
		immediate = '0;
		cfg_valid = 1'b0;
		start_address = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_start(64'd0);

		// Directed part: operand extremes, each class of operation, a store
		// that wraps past the end of data memory, x0 as destination and the
		// ecall cases.
		send_fields(rvx_pkg::OP_LUI, 3'd0, rvx_pkg::F7_BASE, 5'd1, 5'd0, 5'd0, 6'd0,
			32'h7FFF_F000);
		send_fields(rvx_pkg::OP_LUI, 3'd0, rvx_pkg::F7_BASE, 5'd2, 5'd0, 5'd0, 6'd0,
			32'h8000_0000);
		send_fields(rvx_pkg::OP_IMM, rvx_pkg::F3_ADD, rvx_pkg::F7_BASE, 5'd3, 5'd0, 5'd0, 6'd0,
			32'hFFFF_FFFF);
		send_fields(rvx_pkg::OP_REG, rvx_pkg::F3_ADD, rvx_pkg::F7_BASE, 5'd4, 5'd1, 5'd2, 6'd0,
			32'd0);
		send_fields(rvx_pkg::OP_REG, rvx_pkg::F3_ADD, rvx_pkg::F7_ALT, 5'd5, 5'd2, 5'd1, 6'd0,
			32'd0);
		send_fields(rvx_pkg::OP_REG, rvx_pkg::F3_SLT, rvx_pkg::F7_BASE, 5'd6, 5'd2, 5'd1, 6'd0,
			32'd0);
		send_fields(rvx_pkg::OP_REG, rvx_pkg::F3_SLTU, rvx_pkg::F7_BASE, 5'd7, 5'd2, 5'd1, 6'd0,
			32'd0);
		send_fields(rvx_pkg::OP_REG, rvx_pkg::F3_SR, rvx_pkg::F7_ALT, 5'd8, 5'd2, 5'd3, 6'd0,
			32'd0);
		send_fields(rvx_pkg::OP_IMM, rvx_pkg::F3_SLL, rvx_pkg::F7_BASE, 5'd9, 5'd3, 5'd0, 6'd63,
			32'd0);
		send_fields(rvx_pkg::OP_IMM, rvx_pkg::F3_SR, rvx_pkg::F7_ALT, 5'd10, 5'd9, 5'd0, 6'd63,
			32'd0);
		send_fields(rvx_pkg::OP_IMM, rvx_pkg::F3_SR, rvx_pkg::F7_BASE, 5'd11, 5'd9, 5'd0, 6'd63,
			32'd0);
		send_fields(rvx_pkg::OP_STORE, rvx_pkg::F3_SW, rvx_pkg::F7_BASE, 5'd0, 5'd0, 5'd5, 6'd0,
			32'd65534);
		send_fields(rvx_pkg::OP_LOAD, rvx_pkg::F3_LW, rvx_pkg::F7_BASE, 5'd12, 5'd0, 5'd0, 6'd0,
			32'd65534);
		send_fields(rvx_pkg::OP_LOAD, rvx_pkg::F3_LB, rvx_pkg::F7_BASE, 5'd13, 5'd0, 5'd0, 6'd0,
			32'd65535);
		send_fields(rvx_pkg::OP_LOAD, rvx_pkg::F3_LHU, rvx_pkg::F7_BASE, 5'd14, 5'd0, 5'd0, 6'd0,
			32'd65535);
		send_fields(rvx_pkg::OP_BRANCH, rvx_pkg::F3_BLT, rvx_pkg::F7_BASE, 5'd0, 5'd2, 5'd1,
			6'd0, 32'hFFFF_FFF8);
		send_fields(rvx_pkg::OP_BRANCH, rvx_pkg::F3_BGEU, rvx_pkg::F7_BASE, 5'd0, 5'd2, 5'd1,
			6'd0, 32'h8000_0000);
		send_fields(rvx_pkg::OP_JAL, 3'd0, rvx_pkg::F7_BASE, 5'd15, 5'd0, 5'd0, 6'd0,
			32'h7FFF_FFFE);
		send_fields(rvx_pkg::OP_JALR, rvx_pkg::F3_JALR, rvx_pkg::F7_BASE, 5'd16, 5'd3, 5'd0,
			6'd0, 32'd0);
		send_fields(rvx_pkg::OP_AUIPC, 3'd0, rvx_pkg::F7_BASE, 5'd17, 5'd0, 5'd0, 6'd0,
			32'h8000_0000);
		send_fields(rvx_pkg::OP_IMM, rvx_pkg::F3_ADD, rvx_pkg::F7_BASE, 5'd0, 5'd3, 5'd0, 6'd0,
			32'd5);
		send_fields(rvx_pkg::OP_SYSTEM, rvx_pkg::F3_ECALL, rvx_pkg::F7_BASE, 5'd1, 5'd0, 5'd0,
			6'd0, 32'd0);
		send_fields(rvx_pkg::OP_SYSTEM, 3'($urandom_range(1, 7)), rvx_pkg::F7_BASE, 5'd1, 5'd0,
			5'd0, 6'd0, 32'd0);
		send_fields(7'h7F, 3'd7, 7'h7F, 5'd31, 5'd31, 5'd31, 6'd0, 32'd0);
		drain();

		// Random phases, each starting from a different program counter.
		write_start(64'hFFFF_FFFF_FFFF_FFFF);
		random_phase(RANDOM_INSTRS / 4);
		write_start(64'hFFFF_FFFF_FFFF_FFF0);
		random_phase(RANDOM_INSTRS / 4);
		write_start({$urandom(), $urandom()});
		random_phase(RANDOM_INSTRS / 4);
		write_start(64'd0);
		random_phase(RANDOM_INSTRS - 3 * (RANDOM_INSTRS / 4));

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
